// File: hdl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg: shared definitions for the heightmap slope lighting block
// Register indexes, lighting modes, reset values and size defaults.
// ----------------------------------------------------------------------------
package hsl_pkg;

    // Size defaults for the top level parameters.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_DIR_DEF   = 3;

    // Field widths fixed by the interface.
    localparam int HEIGHT_W   = 8;
    localparam int MAP_W_BITS = 11;
    localparam int DIR_BITS   = 2;
    localparam int GAIN_BITS  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_MODE = 3'd0,
        CFG_MAP_WIDTH  = 3'd1,
        CFG_DIR_X      = 3'd2,
        CFG_DIR_Z      = 3'd3,
        CFG_SLOPE_GAIN = 3'd4,
        CFG_MIN_BRIGHT = 3'd5,
        CFG_MAX_BRIGHT = 3'd6
    } cfg_reg_t;

    // Lighting modes; the unused code behaves as full brightness.
    typedef enum logic [1:0] {
        MODE_HEIGHT = 2'd0,
        MODE_SLOPE  = 2'd1,
        MODE_FULL   = 2'd2
    } light_mode_t;

    // Register reset values.
    localparam logic [1:0]            LIGHT_MODE_RST = MODE_SLOPE;
    localparam logic [MAP_W_BITS-1:0] MAP_WIDTH_RST  = 11'd256;
    localparam logic [DIR_BITS-1:0]   DIR_X_RST      = 2'd1;
    localparam logic [DIR_BITS-1:0]   DIR_Z_RST      = 2'd1;
    localparam logic [GAIN_BITS-1:0]  SLOPE_GAIN_RST = 16'd2040;
    localparam logic [HEIGHT_W-1:0]   MIN_BRIGHT_RST = 8'd51;
    localparam logic [HEIGHT_W-1:0]   MAX_BRIGHT_RST = 8'd230;

    // Full brightness, and the same value in Q8.8.
    localparam logic [HEIGHT_W-1:0] FULL_BRIGHT = 8'd255;
    localparam int                  FULL_Q8     = 255 * 256;

endpackage

// File: hdl/heightmap_slope_lighting.sv
// ----------------------------------------------------------------------------
// heightmap_slope_lighting: lightmap generator for a square heightmap
// Turns a raster stream of height bytes into one brightness byte per pixel,
// in height, slope or full brightness mode.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                | Payload                  | Direction
//  --------+--------------------------+--------------------------+----------
//  input   | in_valid / in_stall      | height, frame_start      | into block
//  output  | out_valid / out_stall    | brightness, frame_end    | out of block
//  config  | cfg_we                   | cfg_index, cfg_data      | into block
//
// One word goes in and one comes out every cycle unless a side stalls; a word
// passes the read stage, then the output register. The ring memory, with one
// write and one registered read per taken word, sets that pace and forms the
// read stage. Reset at once clears the position counters and valid flags and
// presets the configuration registers; the ring memory is not cleared and needs
// no pass. While the output is stalled the block keeps taking words until both
// the read stage and the output register are full, then it stalls its input.

module heightmap_slope_lighting #(
    parameter int MAX_WIDTH = hsl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_DIR   = hsl_pkg::MAX_DIR_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [hsl_pkg::HEIGHT_W-1:0]       height,
    input  logic                               frame_start,
    // output words
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hsl_pkg::HEIGHT_W-1:0]       brightness,
    output logic                               frame_end
);

    // The ring keeps MAX_DIR+1 rows; each row has its own slot of MAX_WIDTH
    // entries, and the slot of the current row is tracked alongside it.
    localparam int RING_ROWS  = MAX_DIR + 1;
    localparam int RING_DEPTH = MAX_WIDTH * RING_ROWS;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = $clog2(RING_ROWS);
    localparam int DW = $clog2(MAX_DIR + 1);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int WW = (WB > hsl_pkg::MAP_W_BITS) ? WB : hsl_pkg::MAP_W_BITS;
    localparam int XW = WW + 1;
    localparam int HW = hsl_pkg::HEIGHT_W;
    localparam int PW = hsl_pkg::GAIN_BITS + HW + 2;   // signed product width
    localparam int VW = PW + 1;                        // signed sum width

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                       light_mode_reg;
    logic [hsl_pkg::MAP_W_BITS-1:0]   map_width_reg;
    logic [hsl_pkg::DIR_BITS-1:0]     dir_x_reg;
    logic [hsl_pkg::DIR_BITS-1:0]     dir_z_reg;
    logic [hsl_pkg::GAIN_BITS-1:0]    slope_gain_reg;
    logic [HW-1:0]                    min_bright_reg;
    logic [HW-1:0]                    max_bright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_mode_reg <= hsl_pkg::LIGHT_MODE_RST;
            map_width_reg  <= hsl_pkg::MAP_WIDTH_RST;
            dir_x_reg      <= hsl_pkg::DIR_X_RST;
            dir_z_reg      <= hsl_pkg::DIR_Z_RST;
            slope_gain_reg <= hsl_pkg::SLOPE_GAIN_RST;
            min_bright_reg <= hsl_pkg::MIN_BRIGHT_RST;
            max_bright_reg <= hsl_pkg::MAX_BRIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (hsl_pkg::cfg_reg_t'(cfg_index))
                hsl_pkg::CFG_LIGHT_MODE: light_mode_reg <= cfg_data[1:0];
                hsl_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[hsl_pkg::MAP_W_BITS-1:0];
                hsl_pkg::CFG_DIR_X:      dir_x_reg      <= cfg_data[hsl_pkg::DIR_BITS-1:0];
                hsl_pkg::CFG_DIR_Z:      dir_z_reg      <= cfg_data[hsl_pkg::DIR_BITS-1:0];
                hsl_pkg::CFG_SLOPE_GAIN: slope_gain_reg <= cfg_data[hsl_pkg::GAIN_BITS-1:0];
                hsl_pkg::CFG_MIN_BRIGHT: min_bright_reg <= cfg_data[HW-1:0];
                hsl_pkg::CFG_MAX_BRIGHT: max_bright_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // Effective width and neighbour offsets after saturation.
    logic [WW-1:0] w_eff;
    logic [DW-1:0] dx;
    logic [DW-1:0] dz;

    always_comb
    begin
        if (map_width_reg == '0)
            w_eff = WW'(1);
        else if (WW'(map_width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(map_width_reg);

        dx = (int'(dir_x_reg) > MAX_DIR) ? DW'(MAX_DIR) : DW'(dir_x_reg);
        dz = (int'(dir_z_reg) > MAX_DIR) ? DW'(MAX_DIR) : DW'(dir_z_reg);
    end

    // ------------------------------------------------------------------
    // Handshake: a read stage followed by the output register
    // ------------------------------------------------------------------
    logic rd_valid_reg;
    logic out_valid_reg;
    logic out_take;
    logic rd_move;
    logic in_take;

    assign out_take = !out_valid_reg || !out_stall;
    assign rd_move  = rd_valid_reg && out_take;
    assign in_stall = rd_valid_reg && !out_take;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Raster position
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [SW-1:0] slot_reg, slot_next;

    logic [CW-1:0] c0, c1, col;
    logic [CW-1:0] r0, row;
    logic [CW:0]   r1;
    logic [SW-1:0] s0, s1, slot;
    logic [CW:0]   cn, rn;
    logic          last_pix;

    always_comb
    begin
        // A frame start restarts at the top left corner.
        c0 = frame_start ? '0 : col_reg;
        r0 = frame_start ? '0 : row_reg;
        s0 = frame_start ? '0 : slot_reg;

        // A stored column beyond a narrowed width starts a new row.
        if (XW'(c0) >= XW'(w_eff))
        begin
            c1 = '0;
            r1 = {1'b0, r0} + 1'b1;
            s1 = (s0 == SW'(RING_ROWS - 1)) ? '0 : s0 + 1'b1;
        end
        else
        begin
            c1 = c0;
            r1 = {1'b0, r0};
            s1 = s0;
        end

        col = c1;
        if (XW'(r1) >= XW'(w_eff))
        begin
            row  = '0;
            slot = '0;
        end
        else
        begin
            row  = r1[CW-1:0];
            slot = s1;
        end

        last_pix = (XW'(col) == XW'(w_eff) - 1'b1) && (XW'(row) == XW'(w_eff) - 1'b1);

        // Step on to the next pixel.
        cn = {1'b0, col} + 1'b1;
        rn = {1'b0, row} + 1'b1;
        if (XW'(cn) >= XW'(w_eff))
        begin
            col_next = '0;
            if (XW'(rn) >= XW'(w_eff))
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = rn[CW-1:0];
                slot_next = (slot == SW'(RING_ROWS - 1)) ? '0 : slot + 1'b1;
            end
        end
        else
        begin
            col_next  = cn[CW-1:0];
            row_next  = row;
            slot_next = slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (in_take)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Ring addresses. The neighbour sits dx columns left and dz rows up,
    // each clamped at zero. Its slot is found by stepping back through
    // the ring, as the row number itself is never reduced.
    // ------------------------------------------------------------------
    logic [CW-1:0] pc;
    logic [SW-1:0] ps;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    always_comb
    begin
        if (int'(col) >= int'(dx))
            pc = CW'(int'(col) - int'(dx));
        else
            pc = '0;

        if (int'(row) >= int'(dz))
        begin
            if (int'(slot) >= int'(dz))
                ps = SW'(int'(slot) - int'(dz));
            else
                ps = SW'(int'(slot) + RING_ROWS - int'(dz));
        end
        else
            ps = '0;

        waddr = AW'(int'(slot) * MAX_WIDTH + int'(col));
        raddr = AW'(int'(ps) * MAX_WIDTH + int'(pc));
    end

    // ------------------------------------------------------------------
    // Ring memory: one write and one registered read per accepted word.
    // When both addresses meet, the current height is its own neighbour.
    // ------------------------------------------------------------------
    logic [HW-1:0] ring_mem [RING_DEPTH];
    logic [HW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ring_mem[waddr] <= height;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_data_reg <= ring_mem[raddr];
        end
    end

    // Read stage payload.
    logic [HW-1:0] rd_height_reg;
    logic          rd_same_reg;
    logic          rd_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else if (in_take)
            rd_valid_reg <= 1'b1;
        else if (rd_move)
            rd_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_height_reg <= height;
            rd_same_reg   <= (raddr == waddr);
            rd_last_reg   <= last_pix;
        end
    end

    // ------------------------------------------------------------------
    // Slope mode brightness: 255 - (prev - h) * gain / 256, floored, then
    // clamped to the lower and, last of all, the upper limit.
    // ------------------------------------------------------------------
    logic [HW-1:0]        prev_h;
    logic signed [HW:0]   diff;
    logic signed [PW-1:0] prod;
    logic signed [VW-1:0] val;
    logic [VW-9:0]        quot;
    logic [HW-1:0]        slope_b;
    logic [HW-1:0]        bright_next;

    always_comb
    begin
        prev_h = rd_same_reg ? rd_height_reg : rd_data_reg;
        diff   = signed'({1'b0, prev_h}) - signed'({1'b0, rd_height_reg});
        prod   = PW'(diff) * PW'(signed'({1'b0, slope_gain_reg}));
        val    = VW'(hsl_pkg::FULL_Q8) - VW'(prod);
        quot   = val[VW-1:8];

        // A negative value always falls below the lower limit.
        if (val < 0)
            slope_b = min_bright_reg;
        else if (quot < (VW-8)'(min_bright_reg))
            slope_b = min_bright_reg;
        else if (quot > (VW-8)'(max_bright_reg))
            slope_b = max_bright_reg;
        else
            slope_b = quot[HW-1:0];

        // With crossed limits the upper one is always the answer.
        if (min_bright_reg > max_bright_reg)
            slope_b = max_bright_reg;

        case (hsl_pkg::light_mode_t'(light_mode_reg))
            hsl_pkg::MODE_HEIGHT: bright_next = rd_height_reg;
            hsl_pkg::MODE_SLOPE:  bright_next = slope_b;
            default:              bright_next = hsl_pkg::FULL_BRIGHT;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [HW-1:0] bright_reg;
    logic          frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_take)
            out_valid_reg <= rd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            bright_reg    <= bright_next;
            frame_end_reg <= rd_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign brightness = bright_reg;
    assign frame_end  = frame_end_reg;

endmodule

// File: hdl/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker: port checks for the heightmap slope lighting block
// Watches the handshakes on the top level ports and reports slips.
// ----------------------------------------------------------------------------
module hsl_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] brightness,
    input logic       frame_end
);

    // A stalled output word stays and keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(brightness) && $stable(frame_end))
        else $error("output word changed while stalled");

    // The input is only held back when the output is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output");

    // A fresh output word follows an accepted input word through the read stage.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output word without a matching input word");

    // In the cycle after reset is released nothing leaves and the input is free.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind heightmap_slope_lighting hsl_port_checker u_hsl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .brightness (brightness),
    .frame_end  (frame_end)
);
